// File: sv/bpt_pkg.sv
// Shared constants and types for the cubic Bezier point, tangent and Newton step block.
package bpt_pkg;

   // Guard fraction bits added to the control points during evaluation.
   localparam int GUARD_BITS = 4;

   // Register stages inside the curve and Newton datapath units.
   localparam int AXIS_STAGES   = 6;
   localparam int NEWTON_STAGES = 3;

   // Coordinate width up to which the Newton products use full precision.
   localparam int NEWTON_BASE_WIDTH = 24;

   // Reset values of the control points, Q.8.
   localparam int CTRL0_RESET = 0;
   localparam int CTRL1_RESET = 128;
   localparam int CTRL2_RESET = 128;
   localparam int CTRL3_RESET = 256;

   typedef enum logic [2:0] {
      CSR_CTRL0_X,
      CSR_CTRL0_Y,
      CSR_CTRL1_X,
      CSR_CTRL1_Y,
      CSR_CTRL2_X,
      CSR_CTRL2_Y,
      CSR_CTRL3_X,
      CSR_CTRL3_Y
   } csr_index_type;

endpackage

// File: sv/bpt_axis.sv
// Pipelined de Casteljau evaluator for one axis: point, first and second derivative.
module bpt_axis #(
   parameter int COORD_WIDTH     = 24,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] p0,
   input  logic signed [COORD_WIDTH-1:0] p1,
   input  logic signed [COORD_WIDTH-1:0] p2,
   input  logic signed [COORD_WIDTH-1:0] p3,
   input  logic [PARAM_FRAC_BITS:0]      t,
   output logic signed [COORD_WIDTH-1:0] pt,
   output logic signed [COORD_WIDTH+2:0] d1,
   output logic signed [COORD_WIDTH+4:0] d2
);
   import bpt_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int F   = PARAM_FRAC_BITS;
   localparam int AW  = CW + GUARD_BITS;
   localparam int TW  = F + 2;
   localparam int MW  = AW + 1 + TW;
   localparam int LW  = AW + 2;
   localparam int SMW = LW + 1 + TW;
   localparam int GH  = 1 << (GUARD_BITS - 1);

   localparam logic signed [MW:0]  HALF_M = (MW + 1)'(1) <<< (F - 1);
   localparam logic signed [SMW:0] HALF_S = (SMW + 1)'(1) <<< (F - 1);

   // Guard-bit control points; user changes them only while block idle, unchecked.
   logic signed [AW-1:0] a0, a1, a2, a3;
   logic signed [AW:0]   da01, da12, da23;
   logic signed [LW-1:0] s0, s1;
   logic signed [LW:0]   ds;

   assign a0   = $signed({p0, {GUARD_BITS{1'b0}}});
   assign a1   = $signed({p1, {GUARD_BITS{1'b0}}});
   assign a2   = $signed({p2, {GUARD_BITS{1'b0}}});
   assign a3   = $signed({p3, {GUARD_BITS{1'b0}}});
   assign da01 = (AW + 1)'(a1) - (AW + 1)'(a0);
   assign da12 = (AW + 1)'(a2) - (AW + 1)'(a1);
   assign da23 = (AW + 1)'(a3) - (AW + 1)'(a2);
   assign s0   = LW'(a2) - (LW'(a1) <<< 1) + LW'(a0);
   assign s1   = LW'(a3) - (LW'(a2) <<< 1) + LW'(a1);
   assign ds   = (LW + 1)'(s1) - (LW + 1)'(s0);

   // Stage 1: first level products.
   logic signed [TW-1:0]  ts0;
   logic signed [MW-1:0]  m01_in, m12_in, m23_in, m01_ff, m12_ff, m23_ff;
   logic signed [SMW-1:0] ms_in, ms_ff;
   logic [F:0]            t1_ff;

   assign ts0    = $signed({1'b0, t});
   assign m01_in = da01 * ts0;
   assign m12_in = da12 * ts0;
   assign m23_in = da23 * ts0;
   assign ms_in  = ds * ts0;

   always_ff @(posedge clock) begin
      if (en) begin
         m01_ff <= m01_in;
         m12_ff <= m12_in;
         m23_ff <= m23_in;
         ms_ff  <= ms_in;
         t1_ff  <= t;
      end
   end

   // Stage 2: first level points and the second derivative lerp.
   logic signed [MW:0]   r01, r12, r23;
   logic signed [SMW:0]  rs;
   logic signed [AW-1:0] b0_in, b1_in, b2_in, b0_ff, b1_ff, b2_ff;
   logic signed [LW-1:0] ls_in, ls2_ff;
   logic [F:0]           t2_ff;

   assign r01   = (MW + 1)'(m01_ff) + HALF_M;
   assign r12   = (MW + 1)'(m12_ff) + HALF_M;
   assign r23   = (MW + 1)'(m23_ff) + HALF_M;
   assign rs    = (SMW + 1)'(ms_ff) + HALF_S;
   assign b0_in = a0 + AW'(r01 >>> F);
   assign b1_in = a1 + AW'(r12 >>> F);
   assign b2_in = a2 + AW'(r23 >>> F);
   assign ls_in = s0 + LW'(rs >>> F);

   always_ff @(posedge clock) begin
      if (en) begin
         b0_ff  <= b0_in;
         b1_ff  <= b1_in;
         b2_ff  <= b2_in;
         ls2_ff <= ls_in;
         t2_ff  <= t1_ff;
      end
   end

   // Stage 3: second level products.
   logic signed [TW-1:0] ts2;
   logic signed [AW:0]   db01, db12;
   logic signed [MW-1:0] mc0_in, mc1_in, mc0_ff, mc1_ff;
   logic signed [AW-1:0] b0_3_ff, b1_3_ff;
   logic signed [LW-1:0] ls3_ff;
   logic [F:0]           t3_ff;

   assign ts2    = $signed({1'b0, t2_ff});
   assign db01   = (AW + 1)'(b1_ff) - (AW + 1)'(b0_ff);
   assign db12   = (AW + 1)'(b2_ff) - (AW + 1)'(b1_ff);
   assign mc0_in = db01 * ts2;
   assign mc1_in = db12 * ts2;

   always_ff @(posedge clock) begin
      if (en) begin
         mc0_ff  <= mc0_in;
         mc1_ff  <= mc1_in;
         b0_3_ff <= b0_ff;
         b1_3_ff <= b1_ff;
         ls3_ff  <= ls2_ff;
         t3_ff   <= t2_ff;
      end
   end

   // Stage 4: second level points and the scaled second derivative.
   logic signed [MW:0]   rc0, rc1;
   logic signed [AW-1:0] c0_in, c1_in, c0_ff, c1_ff;
   logic signed [LW+3:0] six_ls;
   logic signed [CW+4:0] d2_in, d2_4_ff;
   logic [F:0]           t4_ff;

   assign rc0    = (MW + 1)'(mc0_ff) + HALF_M;
   assign rc1    = (MW + 1)'(mc1_ff) + HALF_M;
   assign c0_in  = b0_3_ff + AW'(rc0 >>> F);
   assign c1_in  = b1_3_ff + AW'(rc1 >>> F);
   assign six_ls = ((LW + 4)'(ls3_ff) <<< 2) + ((LW + 4)'(ls3_ff) <<< 1) + (LW + 4)'(GH);
   assign d2_in  = (CW + 5)'(six_ls >>> GUARD_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
         d2_4_ff <= d2_in;
         t4_ff   <= t3_ff;
      end
   end

   // Stage 5: last product and the first derivative.
   logic signed [TW-1:0] ts4;
   logic signed [AW:0]   dc;
   logic signed [AW+2:0] three_dc;
   logic signed [MW-1:0] mp_in, mp_ff;
   logic signed [CW+2:0] d1_in, d1_5_ff, d1_6_ff;
   logic signed [AW-1:0] c0_5_ff;
   logic signed [CW+4:0] d2_5_ff, d2_6_ff;

   assign ts4      = $signed({1'b0, t4_ff});
   assign dc       = (AW + 1)'(c1_ff) - (AW + 1)'(c0_ff);
   assign mp_in    = dc * ts4;
   assign three_dc = (AW + 3)'(dc) + ((AW + 3)'(dc) <<< 1) + (AW + 3)'(GH);
   assign d1_in    = (CW + 3)'(three_dc >>> GUARD_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff   <= mp_in;
         d1_5_ff <= d1_in;
         c0_5_ff <= c0_ff;
         d2_5_ff <= d2_4_ff;
      end
   end

   // Stage 6: curve point, rounded back to Q.8.
   logic signed [MW:0]   rp;
   logic signed [AW-1:0] pc;
   logic signed [AW:0]   pc_r;
   logic signed [CW-1:0] pt_in, pt_ff;

   assign rp    = (MW + 1)'(mp_ff) + HALF_M;
   assign pc    = c0_5_ff + AW'(rp >>> F);
   assign pc_r  = (AW + 1)'(pc) + (AW + 1)'(GH);
   assign pt_in = CW'(pc_r >>> GUARD_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff   <= pt_in;
         d1_6_ff <= d1_5_ff;
         d2_6_ff <= d2_5_ff;
      end
   end

   assign pt = pt_ff;
   assign d1 = d1_6_ff;
   assign d2 = d2_6_ff;

endmodule

// File: sv/bpt_newton.sv
// Pipelined Newton numerator and denominator from point, target and derivatives.
module bpt_newton #(
   parameter int  COORD_WIDTH = 24,
   parameter int  SIDE_WIDTH  = 1,
   localparam int NS = (COORD_WIDTH > bpt_pkg::NEWTON_BASE_WIDTH) ?
                       COORD_WIDTH - bpt_pkg::NEWTON_BASE_WIDTH : 0,
   localparam int PW = 2 * COORD_WIDTH + 6 - 2 * NS
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic signed [COORD_WIDTH-1:0] tx,
   input  logic signed [COORD_WIDTH-1:0] ty,
   input  logic signed [COORD_WIDTH+2:0] dx,
   input  logic signed [COORD_WIDTH+2:0] dy,
   input  logic signed [COORD_WIDTH+4:0] sx,
   input  logic signed [COORD_WIDTH+4:0] sy,
   input  logic [SIDE_WIDTH-1:0]         side_in,
   output logic signed [PW-2:0]          num,
   output logic signed [PW+1:0]          den,
   output logic [SIDE_WIDTH-1:0]         side_out
);
   import bpt_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 1 - NS;
   localparam int DW = CW + 3 - NS;
   localparam int SW = CW + 5 - NS;

   logic signed [CW:0]   e_x, e_y;
   logic signed [EW-1:0] ex_in, ey_in, ex_ff, ey_ff;
   logic signed [DW-1:0] ndx_in, ndy_in, ndx_ff, ndy_ff;
   logic signed [SW-1:0] nsx_in, nsy_in, nsx_ff, nsy_ff;
   logic [SIDE_WIDTH-1:0] side1_ff, side2_ff, side3_ff;

   assign e_x = (CW + 1)'(px) - (CW + 1)'(tx);
   assign e_y = (CW + 1)'(py) - (CW + 1)'(ty);

   // Wide coordinates drop low bits so that every product stays as wide as at NEWTON_BASE_WIDTH.
   if (NS == 0) begin : g_full
      assign ex_in  = e_x;
      assign ey_in  = e_y;
      assign ndx_in = dx;
      assign ndy_in = dy;
      assign nsx_in = sx;
      assign nsy_in = sy;
   end else begin : g_scaled
      localparam logic signed [CW+1:0] HE = (CW + 2)'(1) <<< (NS - 1);
      localparam logic signed [CW+3:0] HD = (CW + 4)'(1) <<< (NS - 1);
      localparam logic signed [CW+5:0] HS = (CW + 6)'(1) <<< (NS - 1);
      logic signed [CW+1:0] rex, rey;
      logic signed [CW+3:0] rdx, rdy;
      logic signed [CW+5:0] rsx, rsy;
      assign rex    = (CW + 2)'(e_x) + HE;
      assign rey    = (CW + 2)'(e_y) + HE;
      assign rdx    = (CW + 4)'(dx) + HD;
      assign rdy    = (CW + 4)'(dy) + HD;
      assign rsx    = (CW + 6)'(sx) + HS;
      assign rsy    = (CW + 6)'(sy) + HS;
      assign ex_in  = EW'(rex >>> NS);
      assign ey_in  = EW'(rey >>> NS);
      assign ndx_in = DW'(rdx >>> NS);
      assign ndy_in = DW'(rdy >>> NS);
      assign nsx_in = SW'(rsx >>> NS);
      assign nsy_in = SW'(rsy >>> NS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         ndx_ff   <= ndx_in;
         ndy_ff   <= ndy_in;
         nsx_ff   <= nsx_in;
         nsy_ff   <= nsy_in;
         side1_ff <= side_in;
      end
   end

   logic signed [PW-3:0] pnx_in, pny_in, pnx_ff, pny_ff;
   logic signed [PW-1:0] pdx_in, pdy_in, psx_in, psy_in;
   logic signed [PW-1:0] pdx_ff, pdy_ff, psx_ff, psy_ff;

   assign pnx_in = ex_ff * ndx_ff;
   assign pny_in = ey_ff * ndy_ff;
   assign pdx_in = ndx_ff * ndx_ff;
   assign pdy_in = ndy_ff * ndy_ff;
   assign psx_in = ex_ff * nsx_ff;
   assign psy_in = ey_ff * nsy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pnx_ff   <= pnx_in;
         pny_ff   <= pny_in;
         pdx_ff   <= pdx_in;
         pdy_ff   <= pdy_in;
         psx_ff   <= psx_in;
         psy_ff   <= psy_in;
         side2_ff <= side1_ff;
      end
   end

   logic signed [PW-2:0] num_in, num_ff;
   logic signed [PW+1:0] den_in, den_ff;

   assign num_in = (PW - 1)'(pnx_ff) + (PW - 1)'(pny_ff);
   assign den_in = (PW + 2)'(pdx_ff) + (PW + 2)'(pdy_ff) + (PW + 2)'(psx_ff) +
                   (PW + 2)'(psy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         side3_ff <= side2_ff;
      end
   end

   assign num      = num_ff;
   assign den      = den_ff;
   assign side_out = side3_ff;

endmodule

// File: sv/bpt_div.sv
// Pipelined restoring divider for the Newton quotient, one quotient bit per stage.
module bpt_div #(
   parameter int PARAM_FRAC_BITS = 16,
   parameter int NUM_WIDTH       = 53,
   parameter int DEN_WIDTH       = 56,
   parameter int SIDE_WIDTH      = 1
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [NUM_WIDTH-1:0] num,
   input  logic signed [DEN_WIDTH-1:0] den,
   input  logic [SIDE_WIDTH-1:0]       side_in,
   output logic [PARAM_FRAC_BITS+1:0]  q_mag,
   output logic                        overflow,
   output logic                        negative,
   output logic                        flat,
   output logic [SIDE_WIDTH-1:0]       side_out
);
   import bpt_pkg::*;

   localparam int F  = PARAM_FRAC_BITS;
   localparam int QN = F + 2;
   localparam int UW = DEN_WIDTH - 1;
   localparam int RW = DEN_WIDTH + 1;

   logic [NUM_WIDTH-1:0] an_in;
   logic [UW-1:0]        ud_in;
   logic                 flat_in, ov_in;

   assign an_in   = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
   assign ud_in   = den[UW-1:0];
   assign flat_in = den[DEN_WIDTH-1] || (den == '0);
   assign ov_in   = RW'(an_in) >= {ud_in, 2'b00};

   logic [RW-1:0]         rem_ff  [QN+1];
   logic [F+1:0]          quo_ff  [QN+1];
   logic [UW-1:0]         ud_ff   [QN+1];
   logic                  neg_ff  [QN+1];
   logic                  flat_ff [QN+1];
   logic                  ov_ff   [QN+1];
   logic [SIDE_WIDTH-1:0] side_ff [QN+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= RW'(an_in);
         quo_ff[0]  <= '0;
         ud_ff[0]   <= ud_in;
         neg_ff[0]  <= num[NUM_WIDTH-1];
         flat_ff[0] <= flat_in;
         ov_ff[0]   <= ov_in;
         side_ff[0] <= side_in;
      end
   end

   // The first step tests twice the divisor, the second the divisor itself, and
   // the fraction steps shift the remainder first.
   for (genvar k = 0; k < QN; k++) begin : g_step
      logic [RW-1:0] rem_cur, dvs, rem_in;
      logic          ge;

      if (k >= 2) begin : g_shift
         assign rem_cur = {rem_ff[k][RW-2:0], 1'b0};
      end else begin : g_noshift
         assign rem_cur = rem_ff[k];
      end

      if (k == 0) begin : g_twice
         assign dvs = {1'b0, ud_ff[k], 1'b0};
      end else begin : g_once
         assign dvs = {2'b00, ud_ff[k]};
      end

      assign ge     = rem_cur >= dvs;
      assign rem_in = ge ? rem_cur - dvs : rem_cur;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            quo_ff[k+1]  <= {quo_ff[k][F:0], ge};
            ud_ff[k+1]   <= ud_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            flat_ff[k+1] <= flat_ff[k];
            ov_ff[k+1]   <= ov_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign q_mag    = quo_ff[QN];
   assign overflow = ov_ff[QN];
   assign negative = neg_ff[QN];
   assign flat     = flat_ff[QN];
   assign side_out = side_ff[QN];

endmodule

// File: sv/bezier_point_tangent_newton.sv
// Top level of the cubic Bezier point, tangent and Newton refinement pipeline.
//
// The block holds the four control points of a 2D cubic Bezier curve in eight
// write-only registers on the csr_ port. Each beat on the req_ channel carries a
// curve parameter and a target point; each beat on the rsp_ channel returns the
// curve point, the first derivative and one Newton step of the parameter toward
// the curve point nearest the target, plus flags for a flat denominator and for
// a clamped result. Write the registers only while the pipeline is empty.
//
// Throughput is one beat per cycle while the receiver takes each response. From
// an accepted request to its response a beat passes one input stage, six
// stages of de Casteljau products, three stages of Newton products and sums,
// PARAM_FRAC_BITS + 3 stages of the restoring divider (an input stage, then one
// quotient bit per stage), and the output register. The divider sets the depth.
//
// Reset empties the pipeline and loads the control points with their defaults.
// The whole pipeline advances together: while a response waits in the output
// register and the receiver holds rsp_ready low, every stage holds, req_ready
// is low, and nothing is lost or repeated. Bubbles drain whenever the output is
// free.
module bezier_point_tangent_newton #(
   parameter int COORD_WIDTH     = 24,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [2:0]                        csr_index,
   input  logic [COORD_WIDTH-1:0]            csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [PARAM_FRAC_BITS:0]          req_param_t,
   input  logic signed [COORD_WIDTH-1:0]     req_target_x,
   input  logic signed [COORD_WIDTH-1:0]     req_target_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [COORD_WIDTH-1:0]     rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_point_y,
   output logic signed [COORD_WIDTH+2:0]     rsp_deriv_x,
   output logic signed [COORD_WIDTH+2:0]     rsp_deriv_y,
   output logic signed [PARAM_FRAC_BITS+1:0] rsp_refined_t,
   output logic                              rsp_flat_flag,
   output logic                              rsp_saturated
);
   import bpt_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int F      = PARAM_FRAC_BITS;
   localparam int NS     = (CW > NEWTON_BASE_WIDTH) ? CW - NEWTON_BASE_WIDTH : 0;
   localparam int PW     = 2 * CW + 6 - 2 * NS;
   localparam int SIDE_W = 4 * CW + 7 + F;
   localparam int STAGES = 1 + AXIS_STAGES + NEWTON_STAGES + F + 3;

   localparam logic [F:0] ONE = (F + 1)'(1) << F;

   // Control point registers.
   logic signed [CW-1:0] c0x_ff, c0y_ff, c1x_ff, c1y_ff;
   logic signed [CW-1:0] c2x_ff, c2y_ff, c3x_ff, c3y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0x_ff <= CW'(CTRL0_RESET);
         c0y_ff <= CW'(CTRL0_RESET);
         c1x_ff <= CW'(CTRL1_RESET);
         c1y_ff <= CW'(CTRL1_RESET);
         c2x_ff <= CW'(CTRL2_RESET);
         c2y_ff <= CW'(CTRL2_RESET);
         c3x_ff <= CW'(CTRL3_RESET);
         c3y_ff <= CW'(CTRL3_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CTRL0_X: c0x_ff <= $signed(csr_wdata);
            CSR_CTRL0_Y: c0y_ff <= $signed(csr_wdata);
            CSR_CTRL1_X: c1x_ff <= $signed(csr_wdata);
            CSR_CTRL1_Y: c1y_ff <= $signed(csr_wdata);
            CSR_CTRL2_X: c2x_ff <= $signed(csr_wdata);
            CSR_CTRL2_Y: c2y_ff <= $signed(csr_wdata);
            CSR_CTRL3_X: c3x_ff <= $signed(csr_wdata);
            CSR_CTRL3_Y: c3y_ff <= $signed(csr_wdata);
         endcase
      end
   end

   // One advance signal moves every stage; it is low only while a finished
   // response is held by the receiver.
   logic en;
   logic [STAGES-1:0] vld_ff;
   logic              rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[STAGES-2:0], req_valid};
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   // Input stage: the parameter is clamped to one before any use.
   logic [F:0]           t0_in, t0_ff;
   logic signed [CW-1:0] tx0_ff, ty0_ff;

   assign t0_in = (req_param_t > ONE) ? ONE : req_param_t;

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff  <= t0_in;
         tx0_ff <= req_target_x;
         ty0_ff <= req_target_y;
      end
   end

   // The parameter and target wait alongside the curve evaluation.
   logic [F:0]           dly_t_ff  [AXIS_STAGES];
   logic signed [CW-1:0] dly_tx_ff [AXIS_STAGES];
   logic signed [CW-1:0] dly_ty_ff [AXIS_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         dly_t_ff[0]  <= t0_ff;
         dly_tx_ff[0] <= tx0_ff;
         dly_ty_ff[0] <= ty0_ff;
         for (int i = 1; i < AXIS_STAGES; i++) begin
            dly_t_ff[i]  <= dly_t_ff[i-1];
            dly_tx_ff[i] <= dly_tx_ff[i-1];
            dly_ty_ff[i] <= dly_ty_ff[i-1];
         end
      end
   end

   logic signed [CW-1:0] px, py;
   logic signed [CW+2:0] dx, dy;
   logic signed [CW+4:0] sx, sy;

   bpt_axis #(
      .COORD_WIDTH     (CW),
      .PARAM_FRAC_BITS (F)
   ) u_axis_x (
      .clock (clock),
      .en    (en),
      .p0    (c0x_ff),
      .p1    (c1x_ff),
      .p2    (c2x_ff),
      .p3    (c3x_ff),
      .t     (t0_ff),
      .pt    (px),
      .d1    (dx),
      .d2    (sx)
   );

   bpt_axis #(
      .COORD_WIDTH     (CW),
      .PARAM_FRAC_BITS (F)
   ) u_axis_y (
      .clock (clock),
      .en    (en),
      .p0    (c0y_ff),
      .p1    (c1y_ff),
      .p2    (c2y_ff),
      .p3    (c3y_ff),
      .t     (t0_ff),
      .pt    (py),
      .d1    (dy),
      .d2    (sy)
   );

   // Point, derivative and parameter ride along to the output.
   logic [SIDE_W-1:0]    side_n, side_d, side_o;
   logic signed [PW-2:0] num;
   logic signed [PW+1:0] den;

   assign side_n = {dly_t_ff[AXIS_STAGES-1], px, py, dx, dy};

   bpt_newton #(
      .COORD_WIDTH (CW),
      .SIDE_WIDTH  (SIDE_W)
   ) u_newton (
      .clock    (clock),
      .en       (en),
      .px       (px),
      .py       (py),
      .tx       (dly_tx_ff[AXIS_STAGES-1]),
      .ty       (dly_ty_ff[AXIS_STAGES-1]),
      .dx       (dx),
      .dy       (dy),
      .sx       (sx),
      .sy       (sy),
      .side_in  (side_n),
      .num      (num),
      .den      (den),
      .side_out (side_d)
   );

   logic [F+1:0] q_mag;
   logic         q_ov, q_neg, q_flat;

   bpt_div #(
      .PARAM_FRAC_BITS (F),
      .NUM_WIDTH       (PW - 1),
      .DEN_WIDTH       (PW + 2),
      .SIDE_WIDTH      (SIDE_W)
   ) u_div (
      .clock    (clock),
      .en       (en),
      .num      (num),
      .den      (den),
      .side_in  (side_d),
      .q_mag    (q_mag),
      .overflow (q_ov),
      .negative (q_neg),
      .flat     (q_flat),
      .side_out (side_o)
   );

   // Final step: apply the quotient and clamp, or pass the parameter on when flat, and register the response.
   localparam logic signed [F+3:0] RMAX = ((F + 4)'(1) <<< (F + 1)) - (F + 4)'(1);
   localparam logic signed [F+3:0] RMIN = -((F + 4)'(1) <<< (F + 1));

   logic [F:0]           t_o;
   logic [F+2:0]         qm;
   logic signed [F+3:0]  q_s, diff;
   logic                 over, under;
   logic signed [F+1:0]  refined_in;
   logic                 sat_in;

   assign t_o   = side_o[4*CW+6+F:4*CW+6];
   assign qm    = q_ov ? ((F + 3)'(4) << F) : {1'b0, q_mag};
   assign q_s   = q_neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
   assign diff  = $signed({3'b000, t_o}) - q_s;
   assign over  = diff > RMAX;
   assign under = diff < RMIN;

   always_comb begin
      refined_in = (F + 2)'(diff);
      sat_in     = 1'b0;
      priority if (q_flat) begin
         refined_in = $signed({1'b0, t_o});
      end else if (over) begin
         refined_in = (F + 2)'(RMAX);
         sat_in     = 1'b1;
      end else if (under) begin
         refined_in = (F + 2)'(RMIN);
         sat_in     = 1'b1;
      end else begin
         refined_in = (F + 2)'(diff);
      end
   end

   logic signed [CW-1:0] point_x_ff, point_y_ff;
   logic signed [CW+2:0] deriv_x_ff, deriv_y_ff;
   logic signed [F+1:0]  refined_ff;
   logic                 flat_ff, sat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         point_x_ff <= $signed(side_o[4*CW+5:3*CW+6]);
         point_y_ff <= $signed(side_o[3*CW+5:2*CW+6]);
         deriv_x_ff <= $signed(side_o[2*CW+5:CW+3]);
         deriv_y_ff <= $signed(side_o[CW+2:0]);
         refined_ff <= refined_in;
         flat_ff    <= q_flat;
         sat_ff     <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_point_x   = point_x_ff;
   assign rsp_point_y   = point_y_ff;
   assign rsp_deriv_x   = deriv_x_ff;
   assign rsp_deriv_y   = deriv_y_ff;
   assign rsp_refined_t = refined_ff;
   assign rsp_flat_flag = flat_ff;
   assign rsp_saturated = sat_ff;

endmodule

// File: dv/tb_bezier_point_tangent_newton.sv
// Self-checking testbench for the cubic Bezier point, tangent and Newton step pipeline.
module tb_bezier_point_tangent_newton;
   timeunit 1ns;
   timeprecision 1ps;
   import bpt_pkg::*;

   // Widths of the default build.
   localparam int CW   = 24;
   localparam int PFB  = 16;
   localparam longint ONE_T = 65536;
   // Generous cycle limit; the slowest correct run is far below it.
   localparam int CYCLE_LIMIT = 400000;
   // Pipeline depth plus margin, used before register writes and at the end.
   localparam int DRAIN_CYCLES = 48;

   typedef struct packed {
      logic signed [CW-1:0]  point_x;
      logic signed [CW-1:0]  point_y;
      logic signed [CW+2:0]  deriv_x;
      logic signed [CW+2:0]  deriv_y;
      logic signed [PFB+1:0] refined_t;
      logic                  flat_flag;
      logic                  saturated;
   } projection_type;

   typedef struct packed {
      logic [PFB:0]         param_t;
      logic signed [CW-1:0] target_x;
      logic signed [CW-1:0] target_y;
      logic                 typed;
      projection_type       result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CW-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PFB:0] req_param_t = '0;
   logic signed [CW-1:0] req_target_x = '0;
   logic signed [CW-1:0] req_target_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CW-1:0] rsp_point_x, rsp_point_y;
   logic signed [CW+2:0] rsp_deriv_x, rsp_deriv_y;
   logic signed [PFB+1:0] rsp_refined_t;
   logic rsp_flat_flag, rsp_saturated;

   bezier_point_tangent_newton u_top (.*);

   always #4 clock = ~clock;

   // Local copy of the control points, Q.8.
   longint ctrl_x [4];
   longint ctrl_y [4];

   projection_type pending_results [$];
   int errors = 0;
   int beats_in = 0;
   int beats_out = 0;
   int flat_seen = 0;
   int sat_seen = 0;
   int cycles = 0;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // floor((v + 2^(s-1)) / 2^s): round half toward plus infinity.
   function automatic longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint blend(longint a, longint b, longint t);
      return a + round_shift((b - a) * t, PFB);
   endfunction

   // De Casteljau on one axis with four guard bits: point, B' and B'' in Q.8.
   function automatic void eval_axis(input longint p0, p1, p2, p3, t,
                                     output longint pt, d1, d2);
      longint a0, a1, a2, a3, b0, b1, b2, c0, c1, s0, s1;
      longint cmax, dmax;
      cmax = (longint'(1) <<< (CW - 1)) - 1;
      dmax = (longint'(1) <<< (CW + 2)) - 1;
      a0 = p0 <<< GUARD_BITS; a1 = p1 <<< GUARD_BITS;
      a2 = p2 <<< GUARD_BITS; a3 = p3 <<< GUARD_BITS;
      b0 = blend(a0, a1, t); b1 = blend(a1, a2, t); b2 = blend(a2, a3, t);
      c0 = blend(b0, b1, t); c1 = blend(b1, b2, t);
      s0 = a2 - 2 * a1 + a0;
      s1 = a3 - 2 * a2 + a1;
      pt = clip(round_shift(blend(c0, c1, t), GUARD_BITS), -cmax - 1, cmax);
      d1 = clip(round_shift(3 * (c1 - c0), GUARD_BITS), -dmax - 1, dmax);
      d2 = round_shift(6 * blend(s0, s1, t), GUARD_BITS);
   endfunction

   function automatic projection_type project_point(logic [PFB:0] param_t,
                                                    logic signed [CW-1:0] tx,
                                                    logic signed [CW-1:0] ty);
      projection_type r;
      longint t, px, py, dx, dy, sx, sy, ex, ey, num, den, q, refined;
      longint unsigned an, ud, ip, rem, frac, qmag;
      t = longint'(param_t);
      if (t > ONE_T) t = ONE_T;
      eval_axis(ctrl_x[0], ctrl_x[1], ctrl_x[2], ctrl_x[3], t, px, dx, sx);
      eval_axis(ctrl_y[0], ctrl_y[1], ctrl_y[2], ctrl_y[3], t, py, dy, sy);
      ex = px - longint'(tx);
      ey = py - longint'(ty);
      num = ex * dx + ey * dy;
      den = dx * dx + dy * dy + ex * sx + ey * sy;
      r.flat_flag = 1'b0;
      r.saturated = 1'b0;
      if (den <= 0) begin
         // Flat or concave-away case: the parameter passes through unchanged.
         r.flat_flag = 1'b1;
         refined = t;
      end else begin
         an = num < 0 ? longint'(-num) : num;
         ud = den;
         ip = an / ud;
         if (ip >= 4) begin
            qmag = longint'(4) <<< PFB;
         end else begin
            rem = an % ud;
            frac = 0;
            for (int i = 0; i < PFB; i++) begin
               rem = rem << 1;
               frac = frac << 1;
               if (rem >= ud) begin
                  rem = rem - ud;
                  frac = frac | 1;
               end
            end
            qmag = (ip << PFB) | frac;
         end
         q = num < 0 ? -longint'(qmag) : longint'(qmag);
         refined = t - q;
         if (refined > 2 * ONE_T - 1 || refined < -2 * ONE_T) begin
            r.saturated = 1'b1;
            refined = clip(refined, -2 * ONE_T, 2 * ONE_T - 1);
         end
      end
      r.point_x = CW'(px); r.point_y = CW'(py);
      r.deriv_x = (CW + 3)'(dx); r.deriv_y = (CW + 3)'(dy);
      r.refined_t = (PFB + 2)'(refined);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table. Typed rows are read straight off the default curve
   // (0,0) (0.5,0.5) (0.5,0.5) (1,1), where B' is 1.5 on both axes at both ends.
   // ---------------------------------------------------------------------------
   localparam int N_DIRECTED = 14;
   stim_row_type directed_rows [N_DIRECTED] = '{
      // Start of the curve, target on it: no move.
      '{17'd0, 24'sd0, 24'sd0, 1'b1, '{24'sd0, 24'sd0, 27'sd384, 27'sd384, 18'sd0, 1'b0, 1'b0}},
      // End of the curve, target on it.
      '{17'd65536, 24'sd256, 24'sd256, 1'b1,
        '{24'sd256, 24'sd256, 27'sd384, 27'sd384, 18'sd65536, 1'b0, 1'b0}},
      // Parameter above one is clamped to one.
      '{17'd131071, 24'sd256, 24'sd256, 1'b1,
        '{24'sd256, 24'sd256, 27'sd384, 27'sd384, 18'sd65536, 1'b0, 1'b0}},
      // Far target on the concave side: denominator negative, flat case.
      '{17'd0, -24'sd8388608, -24'sd8388608, 1'b1,
        '{24'sd0, 24'sd0, 27'sd384, 27'sd384, 18'sd0, 1'b1, 1'b0}},
      // Tiny positive denominator: quotient held at 4.0, clamped low.
      '{17'd0, -24'sd191, -24'sd191, 1'b1,
        '{24'sd0, 24'sd0, 27'sd384, 27'sd384, -18'sd131072, 1'b0, 1'b1}},
      // Same at the far end, clamped high.
      '{17'd65536, 24'sd447, 24'sd447, 1'b1,
        '{24'sd256, 24'sd256, 27'sd384, 27'sd384, 18'sd131071, 1'b0, 1'b1}},
      '{17'd0, 24'sd8388607, 24'sd8388607, 1'b0, '0},
      '{17'd32768, 24'sd128, 24'sd128, 1'b0, '0},
      '{17'd1, 24'sd0, -24'sd1, 1'b0, '0},
      '{17'd65535, 24'sd300, 24'sd200, 1'b0, '0},
      '{17'd65537, 24'sd0, 24'sd0, 1'b0, '0},
      '{17'd16384, -24'sd1, 24'sd0, 1'b0, '0},
      '{17'd49152, 24'sd8388607, -24'sd8388608, 1'b0, '0},
      '{17'd21845, 24'sd100, 24'sd20, 1'b0, '0}
   };

   // ---------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------
   int burst_left = 0;

   // Offers one beat, holds it until accepted, then queues its expectation.
   task automatic send_beat(logic [PFB:0] t, logic signed [CW-1:0] tx,
                            logic signed [CW-1:0] ty, logic typed, projection_type typed_r);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid = 1'b1;
      req_param_t = t;
      req_target_x = tx;
      req_target_y = ty;
      do @(posedge clock); while (!req_ready);
      pending_results.insert(pending_results.size(),
                             typed ? typed_r : project_point(t, tx, ty));
      beats_in++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic write_ctrl(csr_index_type idx, logic [CW-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx[0]) ctrl_y[idx >> 1] = longint'($signed(value));
      else ctrl_x[idx >> 1] = longint'($signed(value));
   endtask

   task automatic load_curve(logic [CW-1:0] x0, y0, x1, y1, x2, y2, x3, y3);
      // Registers change only with the pipeline empty.
      req_valid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_ctrl(CSR_CTRL0_X, x0); write_ctrl(CSR_CTRL0_Y, y0);
      write_ctrl(CSR_CTRL1_X, x1); write_ctrl(CSR_CTRL1_Y, y1);
      write_ctrl(CSR_CTRL2_X, x2); write_ctrl(CSR_CTRL2_Y, y2);
      write_ctrl(CSR_CTRL3_X, x3); write_ctrl(CSR_CTRL3_Y, y3);
   endtask

   function automatic logic [CW-1:0] small_coord();
      return CW'($urandom_range(0, 8191) - 4096);
   endfunction

   // Random beats: half aim close to the curve so that small denominators,
   // clamping and sign changes of the step come up often.
   task automatic random_beats(int count);
      logic [PFB:0] t;
      logic signed [CW-1:0] tx, ty;
      projection_type on_curve;
      longint ox, oy;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: t = (PFB + 1)'($urandom_range(65537, 131071));
            1: t = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
            default: t = (PFB + 1)'($urandom_range(0, 65536));
         endcase
         if ($urandom_range(0, 1)) begin
            on_curve = project_point((PFB + 1)'($urandom_range(0, 65536)), '0, '0);
            ox = clip(longint'(on_curve.point_x) + $urandom_range(0, 1023) - 512,
                      -8388608, 8388607);
            oy = clip(longint'(on_curve.point_y) + $urandom_range(0, 1023) - 512,
                      -8388608, 8388607);
            tx = CW'(ox);
            ty = CW'(oy);
         end else begin
            tx = CW'($urandom);
            ty = CW'($urandom);
         end
         send_beat(t, tx, ty, 1'b0, '0);
      end
   endtask

   initial begin
      ctrl_x[0] = CTRL0_RESET; ctrl_y[0] = CTRL0_RESET;
      ctrl_x[1] = CTRL1_RESET; ctrl_y[1] = CTRL1_RESET;
      ctrl_x[2] = CTRL2_RESET; ctrl_y[2] = CTRL2_RESET;
      ctrl_x[3] = CTRL3_RESET; ctrl_y[3] = CTRL3_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].param_t, directed_rows[i].target_x,
                   directed_rows[i].target_y, directed_rows[i].typed,
                   directed_rows[i].result);
      random_beats(60);

      // A small curve around the origin.
      load_curve(small_coord(), small_coord(), small_coord(), small_coord(),
                 small_coord(), small_coord(), small_coord(), small_coord());
      random_beats(100);
      // Control points at opposite extremes of the coordinate range.
      load_curve(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
      random_beats(80);
      // A curve collapsed to one point: zero derivative everywhere.
      load_curve('0, '0, '0, '0, '0, '0, '0, '0);
      random_beats(50);
      // Full-range random control points.
      load_curve(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                 CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
      random_beats(100);
      // All control points at the positive limit.
      load_curve(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
      random_beats(20);
      load_curve(small_coord(), small_coord(), small_coord(), small_coord(),
                 small_coord(), small_coord(), small_coord(), small_coord());
      random_beats(90);
      req_valid = 1'b0;

      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d beats over seven curves, received %0d results.", beats_in, beats_out);
      $display("Flat steps seen: %0d, clamped steps seen: %0d.", flat_seen, sat_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver: short random stalls, stretches of steady acceptance, and one long
   // hold-off while the sender keeps offering, so the pipeline backs up.
   // ---------------------------------------------------------------------------
   int stall_left = 0;
   int mode_left = 0;
   bit steady = 1'b0;
   bit long_hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && beats_in >= 150) begin
            long_hold_done = 1'b1;
            stall_left = 300;
         end
         if (mode_left == 0) begin
            steady = $urandom_range(0, 2) == 0;
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result check against the oldest expectation.
   always @(posedge clock) begin
      projection_type want, got;
      if (rsp_valid && rsp_ready) begin
         got = '{rsp_point_x, rsp_point_y, rsp_deriv_x, rsp_deriv_y,
                 rsp_refined_t, rsp_flat_flag, rsp_saturated};
         beats_out++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%t: result beat with no expectation waiting", $realtime);
         end else begin
            want = pending_results.pop_front();
            flat_seen += want.flat_flag;
            sat_seen += want.saturated;
            if (got.point_x !== want.point_x)
               $display("%t: point_x expected %0d, got %0d", $realtime, want.point_x, got.point_x);
            if (got.point_y !== want.point_y)
               $display("%t: point_y expected %0d, got %0d", $realtime, want.point_y, got.point_y);
            if (got.deriv_x !== want.deriv_x)
               $display("%t: deriv_x expected %0d, got %0d", $realtime, want.deriv_x, got.deriv_x);
            if (got.deriv_y !== want.deriv_y)
               $display("%t: deriv_y expected %0d, got %0d", $realtime, want.deriv_y, got.deriv_y);
            if (got.refined_t !== want.refined_t)
               $display("%t: refined_t expected %0d, got %0d", $realtime,
                        want.refined_t, got.refined_t);
            if (got.flat_flag !== want.flat_flag)
               $display("%t: flat_flag expected %0b, got %0b", $realtime,
                        want.flat_flag, got.flat_flag);
            if (got.saturated !== want.saturated)
               $display("%t: saturated expected %0b, got %0b", $realtime,
                        want.saturated, got.saturated);
            if (got !== want) errors++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycles, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

// File: files.f
sv/bpt_pkg.sv
sv/bpt_axis.sv
sv/bpt_newton.sv
sv/bpt_div.sv
sv/bezier_point_tangent_newton.sv
dv/tb_bezier_point_tangent_newton.sv
